// ===== hw/rtl/mie_pkg.sv =====
// Package for the integer execute block: opcodes, function codes, sequencer states.
// No dependencies.
`default_nettype none
package mie_pkg;
  localparam int THREADS = 16;
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07;
  localparam logic [5:0] OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_SLTI = 6'h0a, OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI = 6'h0c, OP_ORI = 6'h0d, OP_XORI = 6'h0e, OP_LUI = 6'h0f;
  localparam logic [5:0] OP_LB = 6'h20, OP_LH = 6'h21, OP_LW = 6'h23, OP_LBU = 6'h24;
  localparam logic [5:0] OP_LHU = 6'h25, OP_SB = 6'h28, OP_SH = 6'h29, OP_SW = 6'h2b;

  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09;
  localparam logic [5:0] FN_MFHI = 6'h10, FN_MTHI = 6'h11, FN_MFLO = 6'h12, FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV = 6'h1a, FN_DIVU = 6'h1b;
  localparam logic [5:0] FN_ADD = 6'h20, FN_ADDU = 6'h21, FN_SUB = 6'h22, FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24, FN_OR = 6'h25, FN_XOR = 6'h26, FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a, FN_SLTU = 6'h2b;

  localparam logic [1:0] MEM_NONE = 2'd0, MEM_LOAD = 2'd1, MEM_STORE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mips32_integer_execute.sv =====
// MIPS32 integer execute: decode, ALU, branches, address generation, HI/LO per thread.
// Uses mie_pkg. Single module; a shared 33-bit add/subtract unit runs multiply and divide.
// Most instructions pass through ST_IDLE, ST_FIX and ST_OUT; MULT/MULTU, and DIV/DIVU with a
// nonzero divisor, also run the one-bit-a-step multiply or divide loop (ST_MUL/ST_DIV)
// before a second ST_FIX. Throughput: one item at a time; next input after output transfer.
// Reset clears the sequencer and the HI/LO valid bits (HI/LO read as zero until written).
`default_nettype none
module mips32_integer_execute import mie_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [31:0] instr, [63:32] pc, [95:64] rs_value, [127:96] rt_value, [131:128] thread
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [4:0] dest_reg, [5] dest_valid, [37:6] result_value, [38] branch_taken,
  // [70:39] branch_target, [72:71] mem_op, [75:73] mem_size, [76] mem_sign_extend,
  // [108:77] mem_address, [109] illegal
  output logic [111:0]      m_tdata
);
  state_t state, state_next;
  logic [31:0] ins, pcv, a, b;
  logic [TW-1:0] t;
  logic [31:0] hi_word [THREADS];
  logic [31:0] lo_word [THREADS];
  logic [THREADS-1:0] hl_valid;
  logic [5:0] cnt;
  logic [31:0] acc, qr, mc;   // acc: high part / remainder, qr: low part / quotient
  logic neg_q, neg_r;

  logic [4:0] dreg;
  logic wr, taken, ill, sx;
  logic [31:0] res, tgt, addr;
  logic [1:0] mop;
  logic [2:0] msize;
  logic [111:0] obuf;

  logic [5:0] op, fn;
  logic [4:0] rt, rd, sa;
  logic [31:0] imm, simm, nxt, btg, jtg, hi_rd, lo_rd, add_ab, sh_b;
  logic [4:0] shamt;
  logic slt_ab, lt_ab;

  assign op = ins[31:26];
  assign fn = ins[5:0];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign sa = ins[10:6];
  assign imm = {16'd0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign nxt = pcv + 32'd4;
  assign btg = nxt + {simm[29:0], 2'b00};
  assign jtg = {nxt[31:28], ins[25:0], 2'b00};
  assign hi_rd = hl_valid[t] ? hi_word[t] : 32'd0;
  assign lo_rd = hl_valid[t] ? lo_word[t] : 32'd0;
  assign add_ab = a + simm;
  assign slt_ab = $signed(a) < $signed(b);
  assign lt_ab = a < b;
  assign shamt = (fn[2]) ? a[4:0] : sa;

  always_comb begin
    unique case (fn[1:0])
      2'b11: sh_b = 32'($signed(b) >>> shamt);
      2'b10: sh_b = b >> shamt;
      default: sh_b = b << shamt;
    endcase
  end

  // shared unit: 33-bit add (multiply) or subtract (divide)
  logic [32:0] mul_sum, div_diff;
  logic [31:0] div_rem;
  logic sub_op;
  logic [32:0] alu_x, alu_y, alu_out;
  assign sub_op = (state == ST_DIV);
  assign div_rem = {acc[30:0], qr[31]};
  assign alu_x = sub_op ? {acc[31], div_rem} : {1'b0, acc};
  assign alu_y = sub_op ? ~{1'b0, mc} : (qr[0] ? {1'b0, mc} : 33'd0);
  assign alu_out = alu_x + alu_y + {32'd0, sub_op};
  assign mul_sum = alu_out;
  assign div_diff = alu_out;

  always_comb begin
    dreg = 5'd0; wr = 1'b0; res = 32'd0; taken = 1'b0; tgt = 32'd0;
    mop = MEM_NONE; msize = 3'd0; sx = 1'b0; addr = 32'd0; ill = 1'b0;
    priority if (op == OP_SPECIAL) begin
      dreg = rd; wr = 1'b1;
      unique case (fn)
        FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV: res = sh_b;
        FN_JR: begin
          wr = 1'b0; dreg = 5'd0;
          if (a != nxt) begin taken = 1'b1; tgt = a; end
        end
        FN_JALR: begin
          res = nxt;
          if (a != nxt) begin taken = 1'b1; tgt = a; end
        end
        FN_MFHI: res = hi_rd;
        FN_MFLO: res = lo_rd;
        FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU: begin wr = 1'b0; dreg = 5'd0; end
        FN_DIV, FN_DIVU: begin
          wr = 1'b0; dreg = 5'd0; ill = (b == 32'd0);
        end
        FN_ADD, FN_ADDU: res = a + b;
        FN_SUB, FN_SUBU: res = a - b;
        FN_AND: res = a & b;
        FN_OR: res = a | b;
        FN_XOR: res = a ^ b;
        FN_NOR: res = ~(a | b);
        FN_SLT: res = {31'd0, slt_ab};
        FN_SLTU: res = {31'd0, lt_ab};
        default: ill = 1'b1;
      endcase
    end else if (op == OP_REGIMM) begin
      if (rt[3:1] == 3'd0) begin
        if (rt[4]) begin dreg = 5'd31; wr = 1'b1; res = nxt; end
        if ((rt[0] ? !a[31] : a[31]) && btg != nxt) begin taken = 1'b1; tgt = btg; end
      end else ill = 1'b1;
    end else if (op == OP_J || op == OP_JAL) begin
      if (op == OP_JAL) begin dreg = 5'd31; wr = 1'b1; res = nxt; end
      if (jtg != nxt) begin taken = 1'b1; tgt = jtg; end
    end else begin
      unique case (op)
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          logic c;
          unique case (op)
            OP_BEQ: c = (a == b);
            OP_BNE: c = (a != b);
            OP_BLEZ: c = !($signed(b) < $signed(a));
            default: c = $signed(b) < $signed(a);
          endcase
          if (c && btg != nxt) begin taken = 1'b1; tgt = btg; end
        end
        OP_ADDI, OP_ADDIU: begin dreg = rt; wr = 1'b1; res = add_ab; end
        OP_SLTI: begin dreg = rt; wr = 1'b1; res = {31'd0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin dreg = rt; wr = 1'b1; res = {31'd0, a < simm}; end
        OP_ANDI: begin dreg = rt; wr = 1'b1; res = a & imm; end
        OP_ORI: begin dreg = rt; wr = 1'b1; res = a | imm; end
        OP_XORI: begin dreg = rt; wr = 1'b1; res = a ^ imm; end
        OP_LUI: begin dreg = rt; wr = 1'b1; res = {ins[15:0], 16'd0}; end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          dreg = rt; mop = MEM_LOAD; addr = add_ab;
          sx = (op == OP_LB || op == OP_LH);
          msize = (op == OP_LB || op == OP_LBU) ? 3'd1 : (op == OP_LW) ? 3'd4 : 3'd2;
        end
        OP_SB, OP_SH, OP_SW: begin
          mop = MEM_STORE; addr = add_ab; res = b;
          msize = (op == OP_SB) ? 3'd1 : (op == OP_SH) ? 3'd2 : 3'd4;
        end
        default: ill = 1'b1;
      endcase
    end
    if (ill) begin
      dreg = 5'd0; res = 32'd0; tgt = 32'd0; addr = 32'd0; msize = 3'd0; mop = MEM_NONE;
      wr = 1'b0; taken = 1'b0; sx = 1'b0;
    end
    if (dreg == 5'd0) wr = 1'b0;
  end

  logic is_mul, is_div;
  assign is_mul = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
  assign is_div = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU) && (b != 32'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_FIX;
      ST_FIX: begin
        if (cnt == 6'd0 && is_mul) state_next = ST_MUL;
        else if (cnt == 6'd0 && is_div) state_next = ST_DIV;
        else state_next = ST_OUT;
      end
      ST_MUL, ST_DIV: if (cnt == 6'd31) state_next = ST_FIX;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
    m_tdata = obuf;
  end

  logic sgn;
  assign sgn = !fn[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hl_valid <= '0;
      cnt <= 6'd0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cnt <= 6'd0;
          if (s_tvalid) begin
            ins <= s_tdata[31:0];
            pcv <= s_tdata[63:32];
            a <= s_tdata[95:64];
            b <= s_tdata[127:96];
            t <= TW'(32'(s_tdata[131:128]) % THREADS);
          end
        end
        ST_FIX: begin
          obuf <= {2'b00, ill, addr, sx, msize, mop, tgt, taken, res, wr, dreg};
          if (cnt == 6'd0) begin
            if (is_mul || is_div) begin
              acc <= 32'd0;
              qr <= (sgn && a[31]) ? -a : a;
              mc <= (sgn && b[31]) ? -b : b;
              neg_q <= sgn && (a[31] ^ b[31]);
              neg_r <= sgn && (is_mul ? (a[31] ^ b[31]) : a[31]);
            end else if (op == OP_SPECIAL && !ill) begin
              if (fn == FN_MTHI) begin
                hi_word[t] <= a;
                lo_word[t] <= lo_rd;
                hl_valid[t] <= 1'b1;
              end else if (fn == FN_MTLO) begin
                lo_word[t] <= a;
                hi_word[t] <= hi_rd;
                hl_valid[t] <= 1'b1;
              end
            end
          end else if (is_mul) begin
            logic [63:0] p;
            p = neg_q ? -{acc, qr} : {acc, qr};
            hi_word[t] <= p[63:32];
            lo_word[t] <= p[31:0];
            hl_valid[t] <= 1'b1;
          end else begin
            lo_word[t] <= neg_q ? -qr : qr;
            hi_word[t] <= neg_r ? -acc : acc;
            hl_valid[t] <= 1'b1;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 6'd1;
          acc <= mul_sum[32:1];
          qr <= {mul_sum[0], qr[31:1]};
        end
        ST_DIV: begin
          cnt <= cnt + 6'd1;
          if (!div_diff[32]) begin
            acc <= div_diff[31:0];
            qr <= {qr[30:0], 1'b1};
          end else begin
            acc <= div_rem;
            qr <= {qr[30:0], 1'b0};
          end
        end
        default: cnt <= 6'd0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mie_checker.sv =====
// Port checker for mips32_integer_execute, attached by bind.
// Imports mie_pkg; the memory op code is checked by its literal value.
`default_nettype none
module mie_checker import mie_pkg::*; (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [111:0] m_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_ill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[109] |-> m_tdata[108:0] == 109'd0) else $error("illegal not clean");
  a_mop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[72:71] != 2'd3) else $error("bad mem op");
  a_next: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule
bind mips32_integer_execute mie_checker u_chk (.*);
`default_nettype wire
